### rtl/psc_pkg.sv
// Shared types, constants and fixed-point helpers for the sphere contact block.
`timescale 1ns / 1ps
`default_nettype none
package psc_pkg;

  localparam int Q_W    = 32;  // Q16.16 word
  localparam int V_W    = 33;  // node minus centre, exact
  localparam int R_W    = 31;  // radius and stiffness
  localparam int FRAC_W = 16;  // Q16.16 fraction bits
  localparam int NRM_W  = 30;  // normal components are Q2.30

  localparam logic [Q_W-1:0]   Q_ONE   = 32'h0001_0000;
  localparam logic [R_W-1:0]   R_ONE   = 31'h0001_0000;
  localparam logic [2*Q_W-1:0] MAG_POS = 64'h0000_0000_7fff_ffff;
  localparam logic [2*Q_W-1:0] MAG_NEG = 64'h0000_0000_8000_0000;

  typedef enum logic [2:0] {
    REG_CENTER_X      = 3'd0,
    REG_CENTER_Y      = 3'd1,
    REG_CENTER_Z      = 3'd2,
    REG_RADIUS        = 3'd3,
    REG_STIFFNESS     = 3'd4,
    REG_FORCE_SCALE   = 3'd5,
    REG_TANGENT_SCALE = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [Q_W-1:0] cx;
    logic signed [Q_W-1:0] cy;
    logic signed [Q_W-1:0] cz;
    logic [R_W-1:0]        radius;
    logic [R_W-1:0]        stiffness;
    logic signed [Q_W-1:0] force_scale;
    logic signed [Q_W-1:0] tangent_scale;
  } cfg_t;

  typedef struct packed {
    logic                  last;
    logic signed [V_W-1:0] vx;
    logic signed [V_W-1:0] vy;
    logic signed [V_W-1:0] vz;
  } front_item_t;

  // Apply a sign to a magnitude and clamp to the signed 32 bit range.
  function automatic logic signed [Q_W-1:0] sat_from_mag(input logic [2*Q_W-1:0] m,
                                                        input logic neg);
    logic signed [Q_W-1:0] r;
    if (neg) begin
      if (m > MAG_NEG) r = 32'sh8000_0000;
      else             r = $signed(~m[Q_W-1:0] + 1'b1);
    end else begin
      if (m > MAG_POS) r = 32'sh7fff_ffff;
      else             r = $signed(m[Q_W-1:0]);
    end
    return r;
  endfunction

  function automatic logic [Q_W-1:0] mag32(input logic signed [Q_W-1:0] a);
    logic [Q_W-1:0] m;
    m = a;
    if (a[Q_W-1]) m = ~m + 1'b1;
    return m;
  endfunction

  // Sign-magnitude product, shifted right by 16 or 30, truncated toward zero, saturated.
  function automatic logic signed [Q_W-1:0] mul_sat(input logic signed [Q_W-1:0] a,
                                                   input logic signed [Q_W-1:0] b,
                                                   input logic nrm);
    logic [2*Q_W-1:0] pr;
    logic [2*Q_W-1:0] sh;
    pr = {{Q_W{1'b0}}, mag32(a)} * {{Q_W{1'b0}}, mag32(b)};
    sh = nrm ? (pr >> NRM_W) : (pr >> FRAC_W);
    return sat_from_mag(sh, a[Q_W-1] ^ b[Q_W-1]);
  endfunction

endpackage
`default_nettype wire

### rtl/penalty_sphere_contact.sv
// Top level: node-against-sphere penalty contact, one node per cycle when not stalled.
//
//   channel   handshake          payload
//   node in   push / full        node_x, node_y, node_z, last_node
//   result    empty / pop        gap, active, force_*, k_*, done_or_degenerate
//   config    wr_en              wr_index, wr_data
//
// One node enters and one result leaves per cycle when not stalled. From push to
// result a node passes one input stage, the queue, 33 square-root stages, 32
// divider stages and the multiply stages around them. The pipeline stalls as a
// whole while the result register is full and not popped; a 4-entry queue
// absorbs the input stage meanwhile. Synchronous reset clears valids and loads
// register defaults; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module penalty_sphere_contact import psc_pkg::*; #(
  parameter int NUM_DIMS   = 3,
  parameter int FIFO_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic signed [Q_W-1:0] node_x,
  input  logic signed [Q_W-1:0] node_y,
  input  logic signed [Q_W-1:0] node_z,
  input  logic                  last_node,
  output logic                  empty,
  input  logic                  pop,
  output logic signed [Q_W-1:0] gap,
  output logic                  active,
  output logic signed [Q_W-1:0] force_x,
  output logic signed [Q_W-1:0] force_y,
  output logic signed [Q_W-1:0] force_z,
  output logic signed [Q_W-1:0] k_xx,
  output logic signed [Q_W-1:0] k_xy,
  output logic signed [Q_W-1:0] k_xz,
  output logic signed [Q_W-1:0] k_yy,
  output logic signed [Q_W-1:0] k_yz,
  output logic signed [Q_W-1:0] k_zz,
  output logic [1:0]            done_or_degenerate,
  input  logic                  wr_en,
  input  logic [2:0]            wr_index,
  input  logic [Q_W-1:0]        wr_data
);

  cfg_t        cfg;
  logic        fr_valid, fr_ready;
  front_item_t fr_item;
  logic        q_valid, q_ready;
  front_item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cx            <= '0;
      cfg.cy            <= '0;
      cfg.cz            <= '0;
      cfg.radius        <= R_ONE;
      cfg.stiffness     <= R_ONE;
      cfg.force_scale   <= Q_ONE;
      cfg.tangent_scale <= Q_ONE;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CENTER_X:      cfg.cx            <= wr_data;
        REG_CENTER_Y:      cfg.cy            <= wr_data;
        REG_CENTER_Z:      cfg.cz            <= wr_data;
        REG_RADIUS:        cfg.radius        <= wr_data[R_W-1:0];
        REG_STIFFNESS:     cfg.stiffness     <= wr_data[R_W-1:0];
        REG_FORCE_SCALE:   cfg.force_scale   <= wr_data;
        REG_TANGENT_SCALE: cfg.tangent_scale <= wr_data;
        default: ;
      endcase
    end
  end

  psc_front #(.NUM_DIMS(NUM_DIMS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .node_x    (node_x),
    .node_y    (node_y),
    .node_z    (node_z),
    .last_node (last_node),
    .cfg       (cfg),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_item  (fr_item)
  );

  psc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_item  (fr_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  psc_back #(.NUM_DIMS(NUM_DIMS)) u_back (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .rd_valid           (q_valid),
    .rd_ready           (q_ready),
    .rd_item            (q_item),
    .empty              (empty),
    .pop                (pop),
    .gap                (gap),
    .active             (active),
    .force_x            (force_x),
    .force_y            (force_y),
    .force_z            (force_z),
    .k_xx               (k_xx),
    .k_xy               (k_xy),
    .k_xz               (k_xz),
    .k_yy               (k_yy),
    .k_yz               (k_yz),
    .k_zz               (k_zz),
    .done_or_degenerate (done_or_degenerate)
  );

endmodule
`default_nettype wire

### rtl/psc_front.sv
// Input stage: takes a node and forms its offset from the sphere centre.
`timescale 1ns / 1ps
`default_nettype none
module psc_front import psc_pkg::*; #(
  parameter int NUM_DIMS = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic signed [Q_W-1:0] node_x,
  input  logic signed [Q_W-1:0] node_y,
  input  logic signed [Q_W-1:0] node_z,
  input  logic                  last_node,
  input  cfg_t                  cfg,
  output logic                  out_valid,
  input  logic                  out_ready,
  output front_item_t           out_item
);

  logic        fr_valid;
  front_item_t item;
  logic        adv;

  assign adv       = !fr_valid || out_ready;
  assign full      = !adv;
  assign out_valid = fr_valid;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (adv) begin
      fr_valid <= push;
    end
    if (adv) begin
      item.last <= last_node;
      item.vx   <= {node_x[Q_W-1], node_x} - {cfg.cx[Q_W-1], cfg.cx};
      item.vy   <= {node_y[Q_W-1], node_y} - {cfg.cy[Q_W-1], cfg.cy};
      // drop the third axis in a planar build
      if (NUM_DIMS > 2) item.vz <= {node_z[Q_W-1], node_z} - {cfg.cz[Q_W-1], cfg.cz};
      else              item.vz <= '0;
    end
  end

endmodule
`default_nettype wire

### rtl/psc_fifo.sv
// Short queue that decouples the input stage from the arithmetic pipeline.
`timescale 1ns / 1ps
`default_nettype none
module psc_fifo import psc_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_valid,
  output logic        wr_ready,
  input  front_item_t wr_item,
  output logic        rd_valid,
  input  logic        rd_ready,
  output front_item_t rd_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  front_item_t    mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_wr;
  logic           do_rd;

  assign wr_ready = count != CW'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_item  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd)      count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
    if (do_wr) mem[wr_ptr] <= wr_item;
  end

endmodule
`default_nettype wire

### rtl/psc_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module psc_sqrt #(
  parameter int RAD_W = 66
) (
  input  logic               clk,
  input  logic               en,
  input  logic [RAD_W-1:0]   rad,
  output logic [RAD_W/2-1:0] root
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [RAD_W-1:0]  rad_q  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W+1:0]  remx;
    logic [REM_W+1:0]  trial;
    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end
    assign remx  = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign trial = {{(REM_W-ROOT_W){1'b0}}, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (remx >= trial) begin
          rem_q[k]  <= REM_W'(remx - trial);
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= remx[REM_W-1:0];
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b0};
        end
        rad_q[k] <= {rad_in[RAD_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[ROOT_W-1];

endmodule
`default_nettype wire

### rtl/psc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module psc_div #(
  parameter int DEN_W = 31,
  parameter int QUO_W = 32
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [DEN_W+QUO_W:0]   num,
  input  logic [DEN_W-1:0]       den,
  output logic [QUO_W-1:0]       quo
);

  localparam int RW    = DEN_W + 1;
  localparam int NUM_W = RW + QUO_W;

  logic [RW-1:0]    rem_q [QUO_W];
  logic [QUO_W-1:0] lo_q  [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [RW-1:0]    rem_in;
    logic [QUO_W-1:0] lo_in;
    logic [DEN_W-1:0] den_in;
    logic [RW:0]      remx;
    logic [RW:0]      dx;
    if (k == 0) begin : g_first
      // upper part of the numerator is below the divisor by construction
      assign rem_in = num[NUM_W-1:QUO_W];
      assign lo_in  = num[QUO_W-1:0];
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign lo_in  = lo_q[k-1];
      assign den_in = den_q[k-1];
    end
    assign remx = {rem_in, lo_in[QUO_W-1]};
    assign dx   = {2'b00, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        if (remx >= dx) begin
          rem_q[k] <= RW'(remx - dx);
          lo_q[k]  <= {lo_in[QUO_W-2:0], 1'b1};
        end else begin
          rem_q[k] <= remx[RW-1:0];
          lo_q[k]  <= {lo_in[QUO_W-2:0], 1'b0};
        end
        den_q[k] <= den_in;
      end
    end
  end

  assign quo = lo_q[QUO_W-1];

endmodule
`default_nettype wire

### rtl/psc_back.sv
// Arithmetic pipeline: distance, gap, normal, penalty force and tangent stiffness.
`timescale 1ns / 1ps
`default_nettype none
module psc_back import psc_pkg::*; #(
  parameter int NUM_DIMS = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  rd_valid,
  output logic                  rd_ready,
  input  front_item_t           rd_item,
  output logic                  empty,
  input  logic                  pop,
  output logic signed [Q_W-1:0] gap,
  output logic                  active,
  output logic signed [Q_W-1:0] force_x,
  output logic signed [Q_W-1:0] force_y,
  output logic signed [Q_W-1:0] force_z,
  output logic signed [Q_W-1:0] k_xx,
  output logic signed [Q_W-1:0] k_xy,
  output logic signed [Q_W-1:0] k_xz,
  output logic signed [Q_W-1:0] k_yy,
  output logic signed [Q_W-1:0] k_yz,
  output logic signed [Q_W-1:0] k_zz,
  output logic [1:0]            done_or_degenerate
);

  localparam int RAD_W   = 2 * V_W;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int SQ_LAT  = ROOT_W;
  localparam int DIV_LAT = Q_W;
  localparam int N_STG   = 2 + SQ_LAT + 3 + DIV_LAT + 3;
  localparam int DNUM_W  = R_W + 1 + DIV_LAT;

  typedef struct packed {
    logic                  last;
    logic                  active;
    logic                  degen;
    logic signed [Q_W-1:0] gap_o;
    logic signed [Q_W-1:0] gap_lo;
    logic [R_W-1:0]        dlen;
    logic signed [Q_W-1:0] vx;
    logic signed [Q_W-1:0] vy;
    logic signed [Q_W-1:0] vz;
  } cls_t;

  typedef struct packed {
    logic                  last;
    logic                  active;
    logic                  degen;
    logic signed [Q_W-1:0] gap_o;
    logic                  negx;
    logic                  negy;
    logic                  negz;
    logic                  nega;
    logic                  negb;
    logic                  ovfa;
    logic                  ovfb;
    logic signed [Q_W-1:0] q;
  } mid_t;

  logic             en;
  logic [N_STG-1:0] vld;

  assign en       = !vld[N_STG-1] || pop;
  assign rd_ready = en;
  assign empty    = !vld[N_STG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N_STG-2:0], rd_valid};
    end
  end

  // Terms that depend on configuration only; after a write they settle through m_r and t1_r, then t2_r, then t3_r.
  logic signed [Q_W-1:0] m_r, t1_r, t2_r, t3_r;
  always_ff @(posedge clk) begin
    m_r  <= mul_sat(cfg.force_scale, cfg.force_scale, 1'b0);
    t1_r <= mul_sat($signed({1'b0, cfg.radius}), $signed({1'b0, cfg.stiffness}), 1'b0);
    t2_r <= mul_sat(t1_r, m_r, 1'b0);
    t3_r <= mul_sat(t2_r, cfg.tangent_scale, 1'b0);
  end

  // squares and sum
  logic [Q_W-1:0]    mx, my, mz;
  logic [2*Q_W-1:0]  sq_x, sq_y, sq_z;
  front_item_t       s1, s2;
  logic [RAD_W-1:0]  rad;

  assign mx = rd_item.vx[V_W-1] ? Q_W'(-rd_item.vx) : rd_item.vx[Q_W-1:0];
  assign my = rd_item.vy[V_W-1] ? Q_W'(-rd_item.vy) : rd_item.vy[Q_W-1:0];
  assign mz = rd_item.vz[V_W-1] ? Q_W'(-rd_item.vz) : rd_item.vz[Q_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x <= {{Q_W{1'b0}}, mx} * {{Q_W{1'b0}}, mx};
      sq_y <= {{Q_W{1'b0}}, my} * {{Q_W{1'b0}}, my};
      sq_z <= {{Q_W{1'b0}}, mz} * {{Q_W{1'b0}}, mz};
      s1   <= rd_item;
      rad  <= {2'b00, sq_x} + {2'b00, sq_y} + {2'b00, sq_z};
      s2   <= s1;
    end
  end

  // distance
  logic [ROOT_W-1:0] root;
  front_item_t       side_q [SQ_LAT];

  psc_sqrt #(.RAD_W(RAD_W)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= s2;
      for (int i = 1; i < SQ_LAT; i++) side_q[i] <= side_q[i-1];
    end
  end

  // gap and classification
  front_item_t           s35;
  logic signed [V_W+1:0] gap_w;
  cls_t                  c36, c37, c38;
  logic signed [Q_W-1:0] p37, u37, q38, u38;

  assign s35   = side_q[SQ_LAT-1];
  assign gap_w = (V_W+2)'({2'b00, root}) - (V_W+2)'({4'b0000, cfg.radius});

  always_ff @(posedge clk) begin
    if (en) begin
      c36.last   <= s35.last;
      c36.active <= gap_w[V_W+1];
      c36.degen  <= root == '0;
      c36.gap_o  <= (!gap_w[V_W+1] && gap_w[V_W:Q_W-1] != '0) ? 32'sh7fff_ffff
                                                             : gap_w[Q_W-1:0];
      c36.gap_lo <= gap_w[Q_W-1:0];
      c36.dlen   <= root[R_W-1:0];
      c36.vx     <= s35.vx[Q_W-1:0];
      c36.vy     <= s35.vy[Q_W-1:0];
      c36.vz     <= s35.vz[Q_W-1:0];
      p37 <= mul_sat(-c36.gap_lo, $signed({1'b0, cfg.stiffness}), 1'b0);
      u37 <= mul_sat(c36.gap_lo, $signed({1'b0, cfg.stiffness}), 1'b0);
      c37 <= c36;
      q38 <= mul_sat(p37, cfg.force_scale, 1'b0);
      u38 <= mul_sat(u37, cfg.tangent_scale, 1'b0);
      c38 <= c37;
    end
  end

  // divisions by the distance
  logic [Q_W-1:0]    mag_a, mag_b;
  logic [DNUM_W-1:0] num_x, num_y, num_z, num_a, num_b;
  logic [Q_W-1:0]    quo_x, quo_y, quo_z, quo_a, quo_b;
  mid_t              mid_in;
  mid_t              mid_q [DIV_LAT];

  assign mag_a = mag32(t3_r);
  assign mag_b = mag32(u38);
  assign num_x = DNUM_W'(mag32(c38.vx)) << NRM_W;
  assign num_y = DNUM_W'(mag32(c38.vy)) << NRM_W;
  assign num_z = DNUM_W'(mag32(c38.vz)) << NRM_W;
  assign num_a = DNUM_W'(mag_a) << FRAC_W;
  assign num_b = DNUM_W'(mag_b) << FRAC_W;

  always_comb begin
    mid_in.last   = c38.last;
    mid_in.active = c38.active;
    mid_in.degen  = c38.degen;
    mid_in.gap_o  = c38.gap_o;
    mid_in.negx   = c38.vx[Q_W-1];
    mid_in.negy   = c38.vy[Q_W-1];
    mid_in.negz   = c38.vz[Q_W-1];
    mid_in.nega   = t3_r[Q_W-1];
    mid_in.negb   = u38[Q_W-1];
    // quotient would not fit the pipeline's quotient width: clamp later
    mid_in.ovfa   = {{(R_W-FRAC_W){1'b0}}, mag_a[Q_W-1:FRAC_W]} >= c38.dlen;
    mid_in.ovfb   = {{(R_W-FRAC_W){1'b0}}, mag_b[Q_W-1:FRAC_W]} >= c38.dlen;
    mid_in.q      = q38;
  end

  psc_div #(.DEN_W(R_W), .QUO_W(DIV_LAT)) u_div_x (
    .clk(clk), .en(en), .num(num_x), .den(c38.dlen), .quo(quo_x));
  psc_div #(.DEN_W(R_W), .QUO_W(DIV_LAT)) u_div_y (
    .clk(clk), .en(en), .num(num_y), .den(c38.dlen), .quo(quo_y));
  psc_div #(.DEN_W(R_W), .QUO_W(DIV_LAT)) u_div_z (
    .clk(clk), .en(en), .num(num_z), .den(c38.dlen), .quo(quo_z));
  psc_div #(.DEN_W(R_W), .QUO_W(DIV_LAT)) u_div_a (
    .clk(clk), .en(en), .num(num_a), .den(c38.dlen), .quo(quo_a));
  psc_div #(.DEN_W(R_W), .QUO_W(DIV_LAT)) u_div_b (
    .clk(clk), .en(en), .num(num_b), .den(c38.dlen), .quo(quo_b));

  always_ff @(posedge clk) begin
    if (en) begin
      mid_q[0] <= mid_in;
      for (int i = 1; i < DIV_LAT; i++) mid_q[i] <= mid_q[i-1];
    end
  end

  // normal, scale factors, force and stiffness
  mid_t                  m70, m71, m72;
  logic signed [Q_W-1:0] n71x, n71y, n71z, a71, b71;
  logic signed [Q_W-1:0] n72x, n72y, n72z, b72;
  logic signed [Q_W-1:0] an_x, an_y, an_z, f72x, f72y, f72z;
  logic signed [Q_W:0]   dsum_x, dsum_y, dsum_z;
  logic                  comp;
  logic                  has_z;

  assign m70 = mid_q[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      n71x <= sat_from_mag({{Q_W{1'b0}}, quo_x}, m70.negx);
      n71y <= sat_from_mag({{Q_W{1'b0}}, quo_y}, m70.negy);
      n71z <= sat_from_mag({{Q_W{1'b0}}, quo_z}, m70.negz);
      a71  <= sat_from_mag(m70.ovfa ? '1 : {{Q_W{1'b0}}, quo_a}, m70.nega);
      b71  <= sat_from_mag(m70.ovfb ? '1 : {{Q_W{1'b0}}, quo_b}, m70.negb);
      m71  <= m70;
      an_x <= mul_sat(a71, n71x, 1'b1);
      an_y <= mul_sat(a71, n71y, 1'b1);
      an_z <= mul_sat(a71, n71z, 1'b1);
      f72x <= mul_sat(m71.q, n71x, 1'b1);
      f72y <= mul_sat(m71.q, n71y, 1'b1);
      f72z <= mul_sat(m71.q, n71z, 1'b1);
      n72x <= n71x;
      n72y <= n71y;
      n72z <= n71z;
      b72  <= b71;
      m72  <= m71;
    end
  end

  assign comp   = m72.active && !m72.degen;
  assign has_z  = NUM_DIMS > 2;
  assign dsum_x = (Q_W+1)'(mul_sat(an_x, n72x, 1'b1)) + (Q_W+1)'(b72);
  assign dsum_y = (Q_W+1)'(mul_sat(an_y, n72y, 1'b1)) + (Q_W+1)'(b72);
  assign dsum_z = (Q_W+1)'(mul_sat(an_z, n72z, 1'b1)) + (Q_W+1)'(b72);

  function automatic logic signed [Q_W-1:0] sat33(input logic signed [Q_W:0] s);
    logic signed [Q_W-1:0] r;
    if (s[Q_W] != s[Q_W-1]) r = s[Q_W] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else                    r = s[Q_W-1:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      gap                <= m72.gap_o;
      active             <= m72.active;
      done_or_degenerate <= {m72.degen, m72.last};
      force_x <= comp ? f72x : '0;
      force_y <= comp ? f72y : '0;
      force_z <= (comp && has_z) ? f72z : '0;
      k_xx    <= comp ? sat33(dsum_x) : '0;
      k_xy    <= comp ? mul_sat(an_x, n72y, 1'b1) : '0;
      k_xz    <= (comp && has_z) ? mul_sat(an_x, n72z, 1'b1) : '0;
      k_yy    <= comp ? sat33(dsum_y) : '0;
      k_yz    <= (comp && has_z) ? mul_sat(an_y, n72z, 1'b1) : '0;
      k_zz    <= (comp && has_z) ? sat33(dsum_z) : '0;
    end
  end

endmodule
`default_nettype wire

### test/penalty_sphere_contact_tb.sv
// Testbench for the sphere contact block: a shadow model scores every result it pops.
`timescale 1ns / 1ps
module penalty_sphere_contact_tb;
  import psc_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 90;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef logic [11:0][31:0] contact_t;

  logic clk, rst, push, full, empty, pop, last_node, wr_en;
  logic signed [31:0] node_x, node_y, node_z;
  logic signed [31:0] gap, force_x, force_y, force_z;
  logic signed [31:0] k_xx, k_xy, k_xz, k_yy, k_yz, k_zz;
  logic active;
  logic [1:0] done_or_degenerate;
  logic [2:0] wr_index;
  logic [31:0] wr_data;

  penalty_sphere_contact DUT (.*);

  // shadow copy of the configuration
  longint sh_cx, sh_cy, sh_cz, sh_radius, sh_stiff, sh_fscale, sh_tscale;

  contact_t pending[$];
  int errors, nodes_sent, results_seen, active_seen, degen_seen, cycles, stall_pct;
  string field_name[12] = '{"gap", "active", "force_x", "force_y", "force_z", "k_xx",
                            "k_xy", "k_xz", "k_yy", "k_yz", "k_zz", "done_or_degenerate"};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned magn(longint a);
    return a < 0 ? longint'(0) - a : a;
  endfunction

  function automatic longint sat32(longint a);
    if (a > 64'sd2147483647) return 64'sd2147483647;
    if (a < -64'sd2147483648) return -64'sd2147483648;
    return a;
  endfunction

  // product shifted right, truncated toward zero
  function automatic longint mul_trunc(longint a, longint b, int sh);
    logic [127:0] p;
    p = (128'(magn(a)) * 128'(magn(b))) >> sh;
    return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint div_trunc(longint a, longint unsigned d);
    longint unsigned q;
    q = magn(a) / d;
    return a < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic contact_t contact_response(logic signed [31:0] x, logic signed [31:0] y,
                                                logic signed [31:0] z, logic last);
    longint v[3], nrm[3], kt[3][3], frc[3];
    logic [127:0] sumsq, c2;
    longint unsigned dlen, c;
    longint g, p, q, m, t, a, u, b, an, e;
    logic act, degen;
    contact_t r;
    v[0] = longint'(x) - sh_cx;
    v[1] = longint'(y) - sh_cy;
    v[2] = longint'(z) - sh_cz;
    sumsq = '0;
    for (int i = 0; i < 3; i++) sumsq += 128'(magn(v[i])) * 128'(magn(v[i]));
    dlen = 0;
    for (int bt = 35; bt >= 0; bt--) begin
      c = dlen | (64'd1 << bt);
      c2 = 128'(c) * 128'(c);
      if (c2 <= sumsq) dlen = c;
    end
    g = longint'(dlen) - sh_radius;
    act = g < 0;
    degen = dlen == 0;
    for (int i = 0; i < 3; i++) begin
      frc[i] = 0;
      nrm[i] = 0;
      for (int j = 0; j < 3; j++) kt[i][j] = 0;
    end
    if (act && !degen) begin
      for (int i = 0; i < 3; i++) nrm[i] = div_trunc(mul_trunc(v[i], 64'd1 << 30, 0), dlen);
      p = sat32(mul_trunc(-g, sh_stiff, 16));
      q = sat32(mul_trunc(p, sh_fscale, 16));
      for (int i = 0; i < 3; i++) frc[i] = sat32(mul_trunc(q, nrm[i], 30));
      m = sat32(mul_trunc(sh_fscale, sh_fscale, 16));
      t = sat32(mul_trunc(sh_radius, sh_stiff, 16));
      t = sat32(mul_trunc(t, m, 16));
      t = sat32(mul_trunc(t, sh_tscale, 16));
      a = sat32(div_trunc(mul_trunc(t, 65536, 0), dlen));
      u = sat32(mul_trunc(g, sh_stiff, 16));
      u = sat32(mul_trunc(u, sh_tscale, 16));
      b = sat32(div_trunc(mul_trunc(u, 65536, 0), dlen));
      for (int i = 0; i < 3; i++) begin
        an = sat32(mul_trunc(a, nrm[i], 30));
        for (int j = 0; j < 3; j++) begin
          e = sat32(mul_trunc(an, nrm[j], 30));
          kt[i][j] = (i == j) ? sat32(e + b) : e;
        end
      end
    end
    r[0] = 32'(sat32(g));
    r[1] = {31'd0, act};
    for (int i = 0; i < 3; i++) r[2+i] = 32'(frc[i]);
    r[5] = 32'(kt[0][0]);
    r[6] = 32'(kt[0][1]);
    r[7] = 32'(kt[0][2]);
    r[8] = 32'(kt[1][1]);
    r[9] = 32'(kt[1][2]);
    r[10] = 32'(kt[2][2]);
    r[11] = {30'd0, degen, last};
    return r;
  endfunction

  // mirror register writes, predict accepted nodes, score popped results
  always @(posedge clk) begin
    contact_t got, want;
    if (!rst && wr_en) begin
      case (wr_index)
        REG_CENTER_X:      sh_cx = longint'($signed(wr_data));
        REG_CENTER_Y:      sh_cy = longint'($signed(wr_data));
        REG_CENTER_Z:      sh_cz = longint'($signed(wr_data));
        REG_RADIUS:        sh_radius = longint'(wr_data[30:0]);
        REG_STIFFNESS:     sh_stiff = longint'(wr_data[30:0]);
        REG_FORCE_SCALE:   sh_fscale = longint'($signed(wr_data));
        REG_TANGENT_SCALE: sh_tscale = longint'($signed(wr_data));
        default: ;
      endcase
    end
    if (!rst && pop && !empty) begin
      got = {32'(done_or_degenerate), k_zz, k_yz, k_yy, k_xz, k_xy, k_xx,
             force_z, force_y, force_x, 32'(active), gap};
      results_seen++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with no node outstanding", $time);
      end else begin
        want = pending.pop_front();
        if (want[1][0]) active_seen++;
        if (want[11][1]) degen_seen++;
        for (int i = 0; i < 12; i++)
          if (got[i] !== want[i]) begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, field_name[i], want[i], got[i]);
          end
      end
    end
    if (!rst && push && !full) begin
      pending.push_back(contact_response(node_x, node_y, node_z, last_node));
      nodes_sent++;
    end
  end

  // receiver stalls with a rate that is redrawn at random over the run
  always @(posedge clk) begin
    cycles++;
    if (cycles % 64 == 0) stall_pct <= ($urandom_range(3) == 0) ? 0 : $urandom_range(80);
    pop <= ($urandom_range(99) >= stall_pct);
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending.size());
      $display("penalty_sphere_contact_tb: FAIL");
      $finish;
    end
  end

  // leaves push high; caller lowers it through pause_sender or drain
  task automatic send_node(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
    push <= 1'b1;
    node_x <= x;
    node_y <= y;
    node_z <= z;
    last_node <= last;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic pause_sender(int n);
    push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain;
    push <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
  endtask

  task automatic load_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [31:0] rad, logic [31:0] stf, logic [31:0] fs,
                             logic [31:0] ts);
    drain();
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_STIFFNESS, stf);
    write_reg(REG_FORCE_SCALE, fs);
    write_reg(REG_TANGENT_SCALE, ts);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(262144)) - 131072);
      default: return $urandom_range(131072, 32768);
    endcase
  endfunction

  task automatic test_reset_defaults;
    send_node(32'h0, 32'h0, 32'h0, 1'b0);            // node at centre
    send_node(32'h8000, 32'h0, 32'h0, 1'b1);         // inside
    send_node(32'h0, 32'hffff_a000, 32'h3000, 1'b0); // inside, mixed signs
    send_node(32'h20000, 32'h0, 32'h0, 1'b0);        // outside
    send_node(32'h10000, 32'h0, 32'h0, 1'b1);        // on the surface
    send_node(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_node(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    send_node(32'h0, 32'h0, 32'h1, 1'b0);            // tiny offset
  endtask

  task automatic test_extremes;
    load_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h7fff_ffff,
                32'h8000_0000, 32'h8000_0000);
    // far corner: gap saturates; zero radius never activates
    send_node(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    send_node(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    load_sphere(32'h0, 32'h0, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h7fff_ffff);
    send_node(32'h1, 32'h0, 32'h0, 1'b0);
    send_node(32'h0, 32'hffff_ffff, 32'h0, 1'b1);
    send_node(32'h4000_0000, 32'hc000_0000, 32'h2000_0000, 1'b0);
    send_node(32'h0, 32'h0, 32'h0, 1'b1);
    load_sphere(32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h0,
                32'h8000_0000, 32'h7fff_ffff);
    send_node(32'h7fff_0000, 32'h100, 32'h8000_1000, 1'b0);
    send_node(32'h7fff_ffff, 32'h0, 32'h8000_0000, 1'b1);
    drain();
    write_reg(REG_UNUSED, 32'hffff_ffff); // must be ignored
    wr_en <= 1'b0;
    send_node(32'h7000_0000, 32'h0, 32'h9000_0000, 1'b0);
    send_node(32'h7fff_fff0, 32'hffff_fff0, 32'h8000_0010, 1'b1);
  endtask

  task automatic test_random_phase(int count);
    logic [31:0] cx, cy, cz, rad, ox, oy, oz;
    int burst, lim, rb;
    cx = $urandom;
    cy = $urandom;
    cz = $urandom;
    if ($urandom_range(3) == 0) begin
      cx = 32'($signed($urandom_range(2000000)) - 1000000);
      cy = 0;
      cz = 0;
    end
    rb = $urandom_range(30, 10);
    rad = ($urandom_range(4) == 0) ? {1'b0, 31'($urandom_range(32'h7fff_ffff))}
                                   : $urandom_range(32'd1 << rb);
    load_sphere(cx, cy, cz, rad, {1'b0, 31'(pick_scale())}, pick_scale(), pick_scale());
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(40, 1);
        if ($urandom_range(1)) pause_sender($urandom_range(12, 1));
      end
      burst--;
      lim = (rad[30:0] > 31'h3fff_ffff) ? 32'h3fff_ffff : 32'(rad[30:0]) + 2;
      case ($urandom_range(9))
        0, 1: begin
          send_node($urandom, $urandom, $urandom, 1'($urandom_range(1)));
        end
        2: begin
          ox = $urandom_range(4);
          oy = $urandom_range(4);
          oz = $urandom_range(4);
          send_node(cx + ox - 2, cy + oy - 2, cz + oz - 2, 1'($urandom_range(1)));
        end
        default: begin
          ox = $urandom_range(lim);
          oy = $urandom_range(lim);
          oz = $urandom_range(lim);
          send_node(cx + ox - lim / 2, cy + oy - lim / 2, cz + oz - lim / 2,
                    1'($urandom_range(1)));
        end
      endcase
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    wr_en = 1'b0;
    wr_index = REG_CENTER_X;
    wr_data = '0;
    node_x = '0;
    node_y = '0;
    node_z = '0;
    last_node = 1'b0;
    stall_pct = 0;
    cycles = 0;
    sh_cx = 0;
    sh_cy = 0;
    sh_cz = 0;
    sh_radius = 65536;
    sh_stiff = 65536;
    sh_fscale = 65536;
    sh_tscale = 65536;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_extremes();
    for (int ph = 0; ph < 14; ph++) test_random_phase(125);
    drain();
    $display("Nodes sent %0d, results checked %0d (%0d in contact, %0d at centre), 18 spheres.",
             nodes_sent, results_seen, active_seen, degen_seen);
    if (errors == 0 && pending.size() == 0) begin
      $display("penalty_sphere_contact_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending.size());
      $display("penalty_sphere_contact_tb: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/psc_pkg.sv
rtl/psc_front.sv
rtl/psc_fifo.sv
rtl/psc_sqrt.sv
rtl/psc_div.sv
rtl/psc_back.sv
rtl/penalty_sphere_contact.sv
test/penalty_sphere_contact_tb.sv
